// ===== hw/rtl/pfdrc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfdrc_pkg
// Shared types and constants for the packet FIFO with duplicate filter and
// destination/time range count.
// ----------------------------------------------------------------------------
package pfdrc_pkg;

	localparam logic [1:0] MODE_ADD  = 2'd0;
	localparam logic [1:0] MODE_FWD  = 2'd1;
	localparam logic [1:0] MODE_CNT  = 2'd2;

	localparam logic [6:0] CAP_RESET = 7'd64;
	localparam logic [6:0] CAP_MIN   = 7'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] src_id;
		logic [15:0] dest_id;
		logic [31:0] time_value;
		logic [31:0] window_end;
	} in_item_t;

	typedef struct packed {
		logic        accepted;
		logic        has_packet;
		logic [15:0] out_src;
		logic [15:0] out_dest;
		logic [31:0] out_time;
		logic [6:0]  match_count;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} ctl_state_t;

	typedef struct packed {
		logic accept;
		logic scan;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic out_free;
	} ctl_status_t;

endpackage

// ===== hw/rtl/pfdrc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfdrc_ctrl
// Request sequencer: take a request, run the store scan, commit the result.
// ----------------------------------------------------------------------------
module pfdrc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  pfdrc_pkg::ctl_status_t status,
	output pfdrc_pkg::ctl_cmd_t    cmd
);
	import pfdrc_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (status.scan_done) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				// hold until the output register can take the result
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_FINISH: begin
				cmd.finish = status.out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

// ===== hw/rtl/pfdrc_datapath.sv =====
// ----------------------------------------------------------------------------
// pfdrc_datapath
// Entry store, head/occupancy, scan counter, compare/accumulate and the
// result register.
// ----------------------------------------------------------------------------
module pfdrc_datapath #(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pfdrc_pkg::ctl_cmd_t    cmd,
	output pfdrc_pkg::ctl_status_t status,
	input  pfdrc_pkg::in_item_t    in_data,
	input  logic                   cfg_we,
	input  logic [6:0]             cfg_wdata,
	output logic                   out_valid,
	input  logic                   out_stall,
	output pfdrc_pkg::out_item_t   out_data
);
	import pfdrc_pkg::*;

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int OW = $clog2(BUFFER_DEPTH + 1);
	localparam int SW = OW + 1;
	localparam int EW = (OW > 7) ? OW : 7;

	// slot = (head + offset) mod depth, offset never above depth
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] head,
	                                           input logic [OW-1:0] offset);
		logic [SW-1:0] sum;
		sum = SW'(head) + SW'(offset);
		if (sum >= SW'(BUFFER_DEPTH)) sum = sum - SW'(BUFFER_DEPTH);
		return AW'(sum);
	endfunction

	logic [63:0]   mem [BUFFER_DEPTH];
	logic [63:0]   rd_data_s1;
	logic          rd_v_s1;

	in_item_t      item_q;
	logic [6:0]    cap_q;
	logic [AW-1:0] head_q;
	logic [OW-1:0] occ_q;
	logic [OW-1:0] idx_q;
	logic [OW-1:0] cnt_q;
	logic          dup_q;
	out_item_t     out_q;
	logic          out_valid_q;

	logic [OW-1:0] scan_end;
	logic          issue;
	logic [AW-1:0] rd_slot;
	logic [AW-1:0] wr_slot;
	logic [63:0]   add_word;
	logic [EW-1:0] cap_ext;
	logic [EW-1:0] lim_ext;
	logic [OW-1:0] lim;
	logic          full;
	logic          wr_en;
	logic          hit;
	out_item_t     res;

	assign add_word = {item_q.src_id, item_q.dest_id, item_q.time_value};

	// clamp the capacity register to 2..depth
	assign cap_ext = EW'(cap_q);
	always_comb begin
		lim_ext = cap_ext;
		if (cap_ext < EW'(CAP_MIN))     lim_ext = EW'(CAP_MIN);
		if (cap_ext > EW'(BUFFER_DEPTH)) lim_ext = EW'(BUFFER_DEPTH);
	end
	assign lim  = OW'(lim_ext);
	assign full = (occ_q >= lim);

	always_comb begin
		case (item_q.mode)
			MODE_ADD: scan_end = occ_q;
			MODE_CNT: scan_end = occ_q;
			MODE_FWD: scan_end = (occ_q != '0) ? OW'(1) : '0;
			default:  scan_end = '0;
		endcase
	end

	assign issue   = cmd.scan && (idx_q != scan_end);
	assign rd_slot = wrap_add(head_q, idx_q);
	assign wr_slot = wrap_add(head_q, occ_q);
	assign wr_en   = cmd.finish && (item_q.mode == MODE_ADD) && !dup_q;

	assign hit = (rd_data_s1[47:32] == item_q.dest_id)
	          && (rd_data_s1[31:0] >= item_q.time_value)
	          && (rd_data_s1[31:0] <= item_q.window_end);

	assign status.scan_done = (idx_q == scan_end) && !rd_v_s1;
	assign status.out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_slot] <= add_word;
		if (issue) rd_data_s1 <= mem[rd_slot];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) item_q <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
			idx_q   <= '0;
			cnt_q   <= '0;
			dup_q   <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			if (cmd.accept) begin
				idx_q <= '0;
				cnt_q <= '0;
				dup_q <= 1'b0;
			end else begin
				if (issue) idx_q <= idx_q + OW'(1);
				if (rd_v_s1) begin
					if (rd_data_s1 == add_word) dup_q <= 1'b1;
					if (hit) cnt_q <= cnt_q + OW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			occ_q  <= '0;
		end else if (cmd.finish) begin
			case (item_q.mode)
				MODE_ADD: begin
					if (!dup_q) begin
						// evict oldest entries down to limit - 1, then append
						if (full) begin
							head_q <= wrap_add(head_q, occ_q - lim + OW'(1));
							occ_q  <= lim;
						end else begin
							occ_q  <= occ_q + OW'(1);
						end
					end
				end
				MODE_FWD: begin
					if (occ_q != '0) begin
						head_q <= wrap_add(head_q, OW'(1));
						occ_q  <= occ_q - OW'(1);
					end
				end
				default: begin
					occ_q <= occ_q;
				end
			endcase
		end
	end

	always_comb begin
		res = '0;
		case (item_q.mode)
			MODE_ADD: res.accepted = !dup_q;
			MODE_FWD: begin
				if (occ_q != '0) begin
					res.has_packet = 1'b1;
					res.out_src    = rd_data_s1[63:48];
					res.out_dest   = rd_data_s1[47:32];
					res.out_time   = rd_data_s1[31:0];
				end
			end
			MODE_CNT: res.match_count = 7'(cnt_q);
			default:  res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== hw/rtl/packet_fifo_dedup_range_count.sv =====
// Requests are handled one at a time: add and count scan every stored entry,
// forward reads only the head entry, and an unused mode or an empty store
// scans nothing. The next request is accepted once the sequencer is back in idle
// after the result is registered; a full sweep covers all 64 entries.
// Reset clears head, occupancy, sequencer and valid flags and sets the
// capacity register to 64; entry store contents are not cleared.
// ----------------------------------------------------------------------------
// packet_fifo_dedup_range_count
// Bounded packet FIFO with duplicate filter and destination/time range count.
// ----------------------------------------------------------------------------
module packet_fifo_dedup_range_count #(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  pfdrc_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output pfdrc_pkg::out_item_t out_data,
	input  logic                 cfg_we,
	input  logic [6:0]           cfg_wdata
);
	import pfdrc_pkg::*;

	ctl_cmd_t    cmd;
	ctl_status_t status;

	pfdrc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	pfdrc_datapath #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ===== hw/rtl/pfdrc_checker.sv =====
// ----------------------------------------------------------------------------
// pfdrc_checker
// Port-level checks on request sequencing and result encoding.
// ----------------------------------------------------------------------------
module pfdrc_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input pfdrc_pkg::out_item_t out_data
);
	import pfdrc_pkg::*;

	// one request in flight: stall right after an accept
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request accepted while previous still in flight");

	// a result carries at most one kind of answer
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones({out_data.accepted, out_data.has_packet,
		                         out_data.match_count != 7'd0}) <= 1)
		else $error("result mixes answers of different modes");

	// packet fields are zero unless a packet was popped
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.has_packet) |->
		(out_data.out_src == 16'd0 && out_data.out_dest == 16'd0
		 && out_data.out_time == 32'd0))
		else $error("packet fields set without a popped packet");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled result dropped or changed");

endmodule

bind packet_fifo_dedup_range_count pfdrc_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the packet FIFO with duplicate filter and range
// count. Requests are queued by a stimulus block and fed through the input
// handshake under random gaps. Every accepted request is run through a
// behavioral copy of the FIFO, and each returned reply is compared field by
// field with the oldest predicted one. The run covers several capacity
// settings, including out-of-range values and a lowering below occupancy.
// ----------------------------------------------------------------------------
module tb;
	import pfdrc_pkg::*;

	localparam int DEPTH = 64;
	localparam logic [1:0] MODE_NONE = 2'd3;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_PER_SET = 140;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;
	logic      cfg_we = 1'b0;
	logic [6:0] cfg_wdata = '0;

	// pending requests and predicted replies
	in_item_t    request_q[$];
	out_item_t   reply_q[$];
	logic [63:0] recent_words[$];

	// behavioral copy of the packet store
	logic [63:0] slot_word [DEPTH];
	int unsigned head_slot = 0;
	int unsigned fill_level = 0;
	logic [6:0]  cap_reg = CAP_RESET;

	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	int          requests_open = 0;
	logic        req_taken = 1'b0;
	int unsigned fault_count = 0;
	int unsigned cycle_count = 0;

	packet_fifo_dedup_range_count #(
		.BUFFER_DEPTH(DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	function automatic out_item_t apply_request(in_item_t r);
		out_item_t   o;
		logic [63:0] w;
		logic        dup;
		int unsigned lim;
		int unsigned cnt;
		o = '0;
		case (r.mode)
			MODE_ADD: begin
				w = {r.src_id, r.dest_id, r.time_value};
				dup = 1'b0;
				for (int i = 0; i < fill_level; i++) begin
					if (slot_word[(head_slot + i) % DEPTH] == w)
						dup = 1'b1;
				end
				lim = cap_reg;
				if (lim < CAP_MIN)
					lim = CAP_MIN;
				if (lim > DEPTH)
					lim = DEPTH;
				if (!dup) begin
					// evict oldest until there is room under the limit
					while (fill_level >= lim) begin
						head_slot = (head_slot + 1) % DEPTH;
						fill_level--;
					end
					slot_word[(head_slot + fill_level) % DEPTH] = w;
					fill_level++;
					o.accepted = 1'b1;
				end
			end
			MODE_FWD: begin
				if (fill_level > 0) begin
					w = slot_word[head_slot];
					o.has_packet = 1'b1;
					o.out_src = w[63:48];
					o.out_dest = w[47:32];
					o.out_time = w[31:0];
					head_slot = (head_slot + 1) % DEPTH;
					fill_level--;
				end
			end
			MODE_CNT: begin
				cnt = 0;
				for (int i = 0; i < fill_level; i++) begin
					w = slot_word[(head_slot + i) % DEPTH];
					if (w[47:32] == r.dest_id && w[31:0] >= r.time_value &&
							w[31:0] <= r.window_end)
						cnt++;
				end
				o.match_count = cnt[6:0];
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	function automatic in_item_t make_request();
		in_item_t    r;
		int unsigned pick;
		r = '0;
		pick = $urandom_range(99, 0);
		if (pick < 50)
			r.mode = MODE_ADD;
		else if (pick < 70)
			r.mode = MODE_FWD;
		else if (pick < 95)
			r.mode = MODE_CNT;
		else
			r.mode = MODE_NONE;
		// small pools so duplicates and window hits are common
		if ($urandom_range(3, 0) == 0) begin
			{r.src_id, r.dest_id, r.time_value} = {$urandom, $urandom};
		end else begin
			r.src_id = $urandom_range(3, 0);
			r.dest_id = $urandom_range(3, 0);
			r.time_value = $urandom_range(15, 0);
		end
		r.window_end = $urandom;
		if (r.mode == MODE_ADD && recent_words.size() != 0 && $urandom_range(3, 0) == 0)
			{r.src_id, r.dest_id, r.time_value} =
				recent_words[$urandom_range(recent_words.size() - 1, 0)];
		if (r.mode == MODE_CNT && $urandom_range(3, 0) != 0)
			r.window_end = r.time_value + $urandom_range(10, 0) - 2;
		if (r.mode == MODE_ADD) begin
			recent_words.push_back({r.src_id, r.dest_id, r.time_value});
			if (recent_words.size() > 8)
				recent_words.delete(0);
		end
		return r;
	endfunction

	task automatic send(input logic [1:0] mode, input logic [15:0] src,
			input logic [15:0] dest, input logic [31:0] t0, input logic [31:0] t1);
		in_item_t r;
		r.mode = mode;
		r.src_id = src;
		r.dest_id = dest;
		r.time_value = t0;
		r.window_end = t1;
		request_q.push_back(r);
		requests_open++;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (requests_open != 0 || reply_q.size() != 0);
	endtask

	task automatic write_capacity(input logic [6:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		cap_reg = value;
	endtask

	task automatic report_fault(input string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want)
			report_fault($sformatf("%s: expected %0h, got %0h", name, want, got));
	endtask

	// request side: note acceptance and predict the reply
	always @(posedge clk) begin
		req_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			reply_q.push_back(apply_request(in_data));
			requests_open--;
		end
	end

	// driver: advance to the next request once the current one is taken
	always @(negedge clk) begin
		if (!in_valid || req_taken) begin
			if (request_q.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
				in_data <= request_q[0];
				request_q.delete(0);
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99, 0) < rx_idle_pct);
	end

	// monitor
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (reply_q.size() == 0) begin
				report_fault($sformatf("reply with none pending: %h", out_data));
			end else begin
				want = reply_q[0];
				reply_q.delete(0);
				check_field("accepted", want.accepted, out_data.accepted);
				check_field("has_packet", want.has_packet, out_data.has_packet);
				check_field("out_src", want.out_src, out_data.out_src);
				check_field("out_dest", want.out_dest, out_data.out_dest);
				check_field("out_time", want.out_time, out_data.out_time);
				check_field("match_count", want.match_count, out_data.match_count);
			end
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		logic [6:0] set_caps [0:8];
		in_item_t   r;
		set_caps = '{7'd0, 7'd2, 7'd17, 7'd127, 7'd1, 7'd64, 7'd5, 7'd100, 7'd33};
		tx_idle_pct = 36;
		rx_idle_pct = 88;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// empty buffer, extremes, duplicates, windows
		send(MODE_CNT, 16'h0, 16'h0, 32'h0, 32'hFFFF_FFFF);
		send(MODE_FWD, 16'h0, 16'h0, 32'h0, 32'h0);
		send(MODE_NONE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(MODE_ADD, 16'h0, 16'h0, 32'h0, 32'h0);
		send(MODE_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0);
		send(MODE_ADD, 16'h0, 16'h0, 32'h0, 32'hFFFF_FFFF);
		send(MODE_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0);
		send(MODE_ADD, 16'd1, 16'd7, 32'd10, 32'h0);
		send(MODE_ADD, 16'd2, 16'd7, 32'd20, 32'h0);
		send(MODE_ADD, 16'd3, 16'd7, 32'd30, 32'h0);
		send(MODE_ADD, 16'd3, 16'd7, 32'd30, 32'h0);
		send(MODE_CNT, 16'h0, 16'd7, 32'd10, 32'd30);
		send(MODE_CNT, 16'h0, 16'd7, 32'd20, 32'd20);
		send(MODE_CNT, 16'h0, 16'd7, 32'd30, 32'd10);
		send(MODE_CNT, 16'h0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(MODE_CNT, 16'h0, 16'd7, 32'h0, 32'hFFFF_FFFF);
		send(MODE_FWD, 16'h0, 16'h0, 32'h0, 32'h0);
		send(MODE_ADD, 16'h0, 16'h0, 32'h0, 32'h0);
		send(MODE_NONE, 16'h0, 16'h0, 32'h0, 32'h0);
		wait_drained();

		// lower capacity below occupancy: entries stay until the next add
		write_capacity(7'd3);
		send(MODE_CNT, 16'h0, 16'd7, 32'h0, 32'hFFFF_FFFF);
		send(MODE_ADD, 16'd9, 16'd9, 32'd9, 32'h0);
		send(MODE_FWD, 16'h0, 16'h0, 32'h0, 32'h0);
		send(MODE_ADD, 16'd5, 16'd5, 32'd5, 32'h0);
		send(MODE_ADD, 16'd6, 16'd6, 32'd6, 32'h0);
		send(MODE_CNT, 16'h0, 16'd5, 32'd5, 32'd5);
		wait_drained();

		// fill to full depth with one destination, then evict at full
		write_capacity(7'd64);
		for (int i = 0; i < DEPTH; i++)
			send(MODE_ADD, 16'(i), 16'd42, 32'd1000 + i, 32'h0);
		send(MODE_CNT, 16'h0, 16'd42, 32'd1000, 32'd1063);
		send(MODE_ADD, 16'd64, 16'd42, 32'd1064, 32'h0);
		send(MODE_CNT, 16'h0, 16'd42, 32'd1000, 32'd1063);
		send(MODE_CNT, 16'h0, 16'd42, 32'd1000, 32'd1064);
		send(MODE_FWD, 16'h0, 16'h0, 32'h0, 32'h0);
		send(MODE_FWD, 16'h0, 16'h0, 32'h0, 32'h0);
		wait_drained();

		for (int s = 0; s < 9; s++) begin
			if (s == 3) begin
				tx_idle_pct = 88;
				rx_idle_pct = 36;
			end else if (s == 6) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			write_capacity(set_caps[s]);
			for (int k = 0; k < RANDOM_PER_SET; k++) begin
				r = make_request();
				send(r.mode, r.src_id, r.dest_id, r.time_value, r.window_end);
			end
			wait_drained();
		end

		repeat (100) @(negedge clk);
		if (fault_count == 0 && reply_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/pfdrc_pkg.sv
hw/rtl/pfdrc_ctrl.sv
hw/rtl/pfdrc_datapath.sv
hw/rtl/packet_fifo_dedup_range_count.sv
hw/rtl/pfdrc_checker.sv
tb/sv/tb.sv
